/* src/bpmc_pkg.sv */
// Shared types and constants for the button press to MIDI control-change block.
// No dependencies; imported by bpmc_button, button_press_to_midi_cc and the testbench.
package bpmc_pkg;

    localparam int LEVEL_W  = 6;
    localparam int CC_W     = 7;
    localparam int CC_MAP_W = 42;
    localparam int DEB_W    = 10;
    localparam int LONG_W   = 12;
    localparam int MIN_W    = 10;
    localparam int STABLE_W = 11;
    localparam int PRESS_W  = 13;
    localparam int BTN_W    = 3;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 8;
    localparam int CHAN_W   = 4;
    localparam int CFG_IDX_W = 8;

    localparam logic [STABLE_W-1:0] STABLE_MAX = '1;
    localparam logic [PRESS_W-1:0]  PRESS_MAX  = '1;
    localparam logic [STATUS_W-1:0] CC_STATUS  = 8'hB0;
    localparam logic [CC_W-1:0]     CC_VALUE   = 7'h7F;

    localparam logic [CC_MAP_W-1:0] CC_MAP_RST   = 42'd207509045505;
    localparam logic [DEB_W-1:0]    DEBOUNCE_RST = 10'd100;
    localparam logic [LONG_W-1:0]   LONG_RST     = 12'd1000;
    localparam logic [MIN_W-1:0]    MIN_RST      = 10'd30;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CC_MAP   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN      = 8'd3;

    // buttons with special roles
    localparam int BTN_CHAN_DOWN = 4;
    localparam int BTN_CHAN_UP   = 5;

    typedef enum logic [KIND_W-1:0] {
        EV_CC_SENT   = 3'd0,
        EV_CC_DROP   = 3'd1,
        EV_PAIRING   = 3'd2,
        EV_BATTERY   = 3'd3,
        EV_CHAN_DOWN = 3'd4,
        EV_CHAN_UP   = 3'd5
    } kind_t;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce;
        logic [LONG_W-1:0] long_ticks;
        logic [MIN_W-1:0]  min_ticks;
    } btn_cfg_t;

    // per-button status for the current tick
    typedef struct packed {
        logic held;       // held flag before this tick
        logic held_next;  // held flag after this tick
        logic rel;        // accepted release, not discarded
        logic is_long;    // release duration at or above long threshold
    } btn_stat_t;

    typedef struct packed {
        kind_t                kind;
        logic [STATUS_W-1:0]  status;
        logic [CC_W-1:0]      control;
        logic [CC_W-1:0]      data_value;
        logic [CHAN_W-1:0]    channel;
    } ev_t;

endpackage

/* src/button_press_to_midi_cc.sv */
// Top level: button press detector turning debounced releases into MIDI CC, pairing, battery and channel events.
// Depends on bpmc_pkg and bpmc_button.
//
//  channel | direction | handshake          | content
//  s       | in        | s_tvalid/s_tready  | one tick: button levels, link flag
//  m       | out       | m_tvalid/m_tready  | one event, tlast on final event of tick
//  cfg     | in        | cfg_valid/cfg_ready| register write, always ready
//
// A tick goes from the input register through combinational logic into an event
// bank of NUM_BUTTONS slots. The bank then drains one event per cycle while
// m_tready is high, so a tick with n events gives n output beats; one with none
// passes through without using the output.
// The next tick loads in the cycle its predecessor's last event is taken; input
// stalls only while both the input register and the bank are busy.
// Reset is asynchronous, active low; no clearing pass is needed.
module button_press_to_midi_cc
    import bpmc_pkg::*;
#(
    parameter int NUM_BUTTONS = 6,
    parameter int MAX_CHANNEL = 9
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // button_levels[5:0], connected[6], zero[7]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,    // button[2:0], status_byte[10:3],
                                             // control[17:11], data_value[24:18],
                                             // channel[28:25], zero[31:29]
    output logic [KIND_W-1:0]    m_tuser,    // event_kind[2:0]
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CC_MAP_W-1:0]  cfg_data
);

    localparam int CH_W  = $clog2(MAX_CHANNEL + 1);
    localparam int SEL_W = $clog2(NUM_BUTTONS);
    localparam logic [CH_W-1:0] CH_MAX = CH_W'(MAX_CHANNEL);
    localparam logic [CH_W-1:0] CH_ONE = CH_W'(1);

    // configuration
    logic [CC_MAP_W-1:0] cc_map_reg;
    btn_cfg_t            bcfg_reg;

    // input register
    logic               in_valid_reg;
    logic               in_valid_next;
    logic [LEVEL_W-1:0] in_levels_reg;
    logic               in_conn_reg;

    // event bank and channel
    logic [NUM_BUTTONS-1:0] ev_valid_reg;
    logic [NUM_BUTTONS-1:0] ev_valid_next;
    logic [NUM_BUTTONS-1:0] ev_mask_new;
    logic [NUM_BUTTONS-1:0] rest_mask;
    ev_t                    ev_slot_reg [NUM_BUTTONS];
    ev_t                    ev_new      [NUM_BUTTONS];
    logic [CH_W-1:0]        chan_reg;
    logic [CH_W-1:0]        chan_next;

    btn_stat_t        stat [NUM_BUTTONS];
    logic [SEL_W-1:0] sel;
    logic             in_accept;
    logic             out_accept;
    logic             bank_load;
    ev_t              ev_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_map_reg          <= CC_MAP_RST;
            bcfg_reg.debounce   <= DEBOUNCE_RST;
            bcfg_reg.long_ticks <= LONG_RST;
            bcfg_reg.min_ticks  <= MIN_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CC_MAP:   cc_map_reg          <= cfg_data;
                REG_DEBOUNCE: bcfg_reg.debounce   <= cfg_data[DEB_W-1:0];
                REG_LONG:     bcfg_reg.long_ticks <= cfg_data[LONG_W-1:0];
                REG_MIN:      bcfg_reg.min_ticks  <= cfg_data[MIN_W-1:0];
                default:      ;
            endcase
        end
    end

    // per-button debounce and timing
    for (genvar gi = 0; gi < NUM_BUTTONS; gi++)
    begin : g_btn
        logic lvl;
        if (gi < LEVEL_W)
        begin : g_pin
            assign lvl = in_levels_reg[gi];
        end
        else
        begin : g_nopin
            assign lvl = 1'b0;
        end

        bpmc_button u_btn (
            .clk   (clk),
            .rst_n (rst_n),
            .load  (bank_load),
            .level (lvl),
            .cfg   (bcfg_reg),
            .stat  (stat[gi])
        );
    end

    // event generation, buttons in index order
    always_comb
    begin
        logic [CH_W-1:0] ch;
        logic [3:0]      hv;
        ch          = chan_reg;
        ev_mask_new = '0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            // earlier buttons already updated this tick, the rest not yet
            for (int j = 0; j < 4; j++)
            begin
                hv[j] = (j < i) ? stat[j].held_next : stat[j].held;
            end
            ev_new[i].kind       = EV_CC_SENT;
            ev_new[i].status     = '0;
            ev_new[i].control    = '0;
            ev_new[i].data_value = '0;
            if (stat[i].rel)
            begin
                if (stat[i].is_long)
                begin
                    if (i == BTN_CHAN_DOWN)
                    begin
                        ch             = (ch <= CH_ONE) ? CH_MAX : ch - CH_ONE;
                        ev_new[i].kind = EV_CHAN_DOWN;
                        ev_mask_new[i] = 1'b1;
                    end
                    else if (i == BTN_CHAN_UP)
                    begin
                        ch             = (ch >= CH_MAX) ? CH_ONE : ch + CH_ONE;
                        ev_new[i].kind = EV_CHAN_UP;
                        ev_mask_new[i] = 1'b1;
                    end
                end
                else if (hv[0] && hv[1])
                begin
                    ev_new[i].kind = EV_PAIRING;
                    ev_mask_new[i] = 1'b1;
                end
                else if (hv[2] && hv[3])
                begin
                    ev_new[i].kind = EV_BATTERY;
                    ev_mask_new[i] = 1'b1;
                end
                else
                begin
                    ev_new[i].kind       = in_conn_reg ? EV_CC_SENT : EV_CC_DROP;
                    ev_new[i].status     = CC_STATUS | {4'b0000, 4'(ch - CH_ONE)};
                    ev_new[i].control    = CC_W'(cc_map_reg >> (CC_W * i));
                    ev_new[i].data_value = CC_VALUE;
                    ev_mask_new[i]       = 1'b1;
                end
            end
            ev_new[i].channel = CHAN_W'(ch);
        end
        chan_next = ch;
    end

    // output selection: lowest pending slot
    always_comb
    begin
        sel = '0;
        for (int k = NUM_BUTTONS - 1; k >= 0; k--)
        begin
            if (ev_valid_reg[k])
            begin
                sel = SEL_W'(k);
            end
        end
        rest_mask      = ev_valid_reg;
        rest_mask[sel] = 1'b0;
        ev_out         = ev_slot_reg[sel];
    end

    assign m_tvalid   = |ev_valid_reg;
    assign m_tlast    = (rest_mask == '0);
    assign m_tuser    = ev_out.kind;
    assign m_tdata    = {3'b000, ev_out.channel, ev_out.data_value, ev_out.control,
                         ev_out.status, BTN_W'(sel)};
    assign out_accept = m_tvalid && m_tready;
    assign bank_load  = in_valid_reg && (!m_tvalid || (m_tready && rest_mask == '0));
    assign s_tready   = !in_valid_reg || bank_load;
    assign in_accept  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (bank_load)
        begin
            in_valid_next = 1'b0;
        end

        ev_valid_next = ev_valid_reg;
        if (bank_load)
        begin
            ev_valid_next = ev_mask_new;
        end
        else if (out_accept)
        begin
            ev_valid_next = rest_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            ev_valid_reg <= '0;
            chan_reg     <= CH_ONE;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            ev_valid_reg <= ev_valid_next;
            if (bank_load)
            begin
                chan_reg <= chan_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_levels_reg <= s_tdata[LEVEL_W-1:0];
            in_conn_reg   <= s_tdata[LEVEL_W];
        end
        if (bank_load)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                ev_slot_reg[i] <= ev_new[i];
            end
        end
    end

`ifndef SYNTHESIS
    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        chan_reg >= CH_ONE && chan_reg <= CH_MAX)
        else $error("channel out of range");

    a_load_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        bank_load |-> (ev_valid_reg == '0 || (m_tready && $onehot(ev_valid_reg))))
        else $error("event bank reloaded with events pending");

    a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> $onehot(ev_valid_reg))
        else $error("last flag with more events pending");

    a_drain_one: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && !bank_load) |=>
            $countones(ev_valid_reg) == $countones($past(ev_valid_reg)) - 1)
        else $error("event bank did not drop exactly one event");
`endif

endmodule

/* src/bpmc_button.sv */
// Debounce and press timer for one button.
// Depends on bpmc_pkg.
module bpmc_button
    import bpmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  logic      level,
    input  btn_cfg_t  cfg,
    output btn_stat_t stat
);

    logic                last_level_reg;
    logic [STABLE_W-1:0] stable_reg;
    logic                held_reg;
    logic [PRESS_W-1:0]  press_reg;

    logic [STABLE_W-1:0] stable_next;
    logic [PRESS_W-1:0]  press_inc;
    logic [PRESS_W-1:0]  press_next;
    logic                held_next;
    logic                accept_lvl;
    logic                release_hit;

    always_comb
    begin
        press_inc = press_reg;
        if (held_reg && press_reg != PRESS_MAX)
        begin
            press_inc = press_reg + PRESS_W'(1);
        end

        if (level != last_level_reg)
        begin
            stable_next = '0;
        end
        else if (stable_reg != STABLE_MAX)
        begin
            stable_next = stable_reg + STABLE_W'(1);
        end
        else
        begin
            stable_next = stable_reg;
        end

        accept_lvl  = stable_next > STABLE_W'(cfg.debounce);
        press_next  = press_inc;
        held_next   = held_reg;
        release_hit = 1'b0;
        if (accept_lvl && !level && !held_reg)
        begin
            held_next  = 1'b1;
            press_next = '0;
        end
        else if (accept_lvl && level && held_reg)
        begin
            held_next   = 1'b0;
            release_hit = 1'b1;
        end

        stat.held      = held_reg;
        stat.held_next = held_next;
        stat.rel       = release_hit && (press_inc >= PRESS_W'(cfg.min_ticks));
        stat.is_long   = press_inc >= PRESS_W'(cfg.long_ticks);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= 1'b1;
            stable_reg     <= '0;
            held_reg       <= 1'b0;
            press_reg      <= '0;
        end
        else if (load)
        begin
            last_level_reg <= level;
            stable_reg     <= stable_next;
            held_reg       <= held_next;
            press_reg      <= press_next;
        end
    end

endmodule

/* test/tb_button_press_to_midi_cc.sv */
// Testbench for button_press_to_midi_cc: feeds millisecond ticks of button levels,
// predicts the MIDI events of each tick and checks them on the output stream.
// Depends on bpmc_pkg and the button_press_to_midi_cc RTL.
module tb_button_press_to_midi_cc;
    import bpmc_pkg::*;

    localparam int NUM_BTN       = 6;
    localparam int MAX_CH        = 9;
    localparam int HALF_PERIOD   = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int LONG_HOLD     = 300;
    localparam longint TIMEOUT   = 20_000_000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;

    typedef struct packed {
        kind_t               kind;
        logic [BTN_W-1:0]    btn;
        logic [STATUS_W-1:0] status;
        logic [CC_W-1:0]     control;
        logic [CC_W-1:0]     value;
        logic [CHAN_W-1:0]   channel;
        logic                last;
    } midi_event_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CC_MAP_W-1:0]  cfg_data  = '0;

    // predicted block state
    logic [CC_MAP_W-1:0] cc_map_q   = CC_MAP_RST;
    logic [DEB_W-1:0]    debounce_q = DEBOUNCE_RST;
    logic [LONG_W-1:0]   long_q     = LONG_RST;
    logic [MIN_W-1:0]    min_q      = MIN_RST;
    logic                level_q  [NUM_BTN] = '{default: 1'b1};
    logic [STABLE_W-1:0] stable_q [NUM_BTN] = '{default: '0};
    logic                held_q   [NUM_BTN] = '{default: 1'b0};
    logic [PRESS_W-1:0]  press_q  [NUM_BTN] = '{default: '0};
    logic [CHAN_W-1:0]   channel_q = 4'd1;

    midi_event_t    expected_events [$];
    midi_event_t    exp_ev;
    midi_event_t    seen_ev;
    logic [7:0]     tick_q [$];
    logic [LEVEL_W-1:0] walk_levels = '1;

    logic tick_taken   = 1'b0;
    bit   send_idle    = 1'b1;
    bit   sink_idle    = 1'b1;
    bit   hold_request = 1'b0;
    bit   hold_done    = 1'b0;
    int   send_gap     = 0;
    int   stall_left   = 0;
    int   failures     = 0;

    button_press_to_midi_cc #(
        .NUM_BUTTONS(NUM_BTN),
        .MAX_CHANNEL(MAX_CH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(HALF_PERIOD) clk = ~clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic midi_event_t make_event(kind_t kind, int btn,
                                               logic [STATUS_W-1:0] status,
                                               logic [CC_W-1:0] control,
                                               logic [CC_W-1:0] value);
        midi_event_t ev;
        ev.kind    = kind;
        ev.btn     = BTN_W'(btn);
        ev.status  = status;
        ev.control = control;
        ev.value   = value;
        ev.channel = channel_q;
        ev.last    = 1'b0;
        return ev;
    endfunction

    // debounce, time and classify every button for one tick
    function automatic void predict_tick(logic [LEVEL_W-1:0] levels, logic link);
        midi_event_t        tick_events [$];
        midi_event_t        ev;
        logic [PRESS_W-1:0] dur;
        logic               cur;
        for (int i = 0; i < NUM_BTN; i++)
        begin
            cur = levels[i];
            if (held_q[i] && press_q[i] != PRESS_MAX)
                press_q[i]++;
            if (cur != level_q[i])
                stable_q[i] = '0;
            else if (stable_q[i] != STABLE_MAX)
                stable_q[i]++;
            if (stable_q[i] > STABLE_W'(debounce_q))
            begin
                if (!cur && !held_q[i])
                begin
                    held_q[i]  = 1'b1;
                    press_q[i] = '0;
                end
                else if (cur && held_q[i])
                begin
                    dur = press_q[i];
                    if (dur >= PRESS_W'(min_q))
                    begin
                        if (dur >= PRESS_W'(long_q))
                        begin
                            if (i == BTN_CHAN_DOWN)
                            begin
                                channel_q = (channel_q <= 4'd1) ? CHAN_W'(MAX_CH)
                                                                : channel_q - 4'd1;
                                tick_events.push_back(make_event(EV_CHAN_DOWN, i, '0, '0, '0));
                            end
                            else if (i == BTN_CHAN_UP)
                            begin
                                channel_q = (channel_q >= CHAN_W'(MAX_CH)) ? 4'd1
                                                                           : channel_q + 4'd1;
                                tick_events.push_back(make_event(EV_CHAN_UP, i, '0, '0, '0));
                            end
                        end
                        else if (held_q[0] && held_q[1])
                            tick_events.push_back(make_event(EV_PAIRING, i, '0, '0, '0));
                        else if (held_q[2] && held_q[3])
                            tick_events.push_back(make_event(EV_BATTERY, i, '0, '0, '0));
                        else
                            tick_events.push_back(make_event(
                                link ? EV_CC_SENT : EV_CC_DROP, i,
                                CC_STATUS | {4'h0, 4'(channel_q - 4'd1)},
                                cc_map_q[CC_W*i +: CC_W], CC_VALUE));
                    end
                    held_q[i] = 1'b0;
                end
            end
            level_q[i] = cur;
        end
        foreach (tick_events[k])
        begin
            ev      = tick_events[k];
            ev.last = (k == tick_events.size() - 1);
            expected_events.push_back(ev);
        end
    endfunction

    // tick driver
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || tick_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (tick_q.size() != 0)
            begin
                s_tdata  <= tick_q.pop_front();
                s_tvalid <= 1'b1;
                send_gap = (send_idle && $urandom_range(0, 99) < 40) ? idle_len() : 0;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // event sink with random and long stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_request && !hold_done)
        begin
            hold_done  = 1'b1;
            stall_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (sink_idle && $urandom_range(0, 99) < 25)
        begin
            stall_left = idle_len() - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // monitor: check events first, then predict the tick taken at this edge
    always @(posedge clk)
    begin
        tick_taken <= s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_events.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected event: tuser=%0d tdata=%h tlast=%b",
                             m_tuser, m_tdata, m_tlast);
            end
            else
            begin
                exp_ev          = expected_events.pop_front();
                seen_ev.kind    = kind_t'(m_tuser);
                seen_ev.btn     = m_tdata[2:0];
                seen_ev.status  = m_tdata[10:3];
                seen_ev.control = m_tdata[17:11];
                seen_ev.value   = m_tdata[24:18];
                seen_ev.channel = m_tdata[28:25];
                seen_ev.last    = m_tlast;
                if (seen_ev !== exp_ev || m_tdata[31:29] !== 3'b000)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display({"event mismatch: expected kind=%0d btn=%0d status=%h ",
                                  "ctl=%0d val=%0d ch=%0d last=%b, got kind=%0d btn=%0d ",
                                  "status=%h ctl=%0d val=%0d ch=%0d last=%b pad=%b"},
                                 exp_ev.kind, exp_ev.btn, exp_ev.status, exp_ev.control,
                                 exp_ev.value, exp_ev.channel, exp_ev.last,
                                 seen_ev.kind, seen_ev.btn, seen_ev.status, seen_ev.control,
                                 seen_ev.value, seen_ev.channel, seen_ev.last,
                                 m_tdata[31:29]);
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
            predict_tick(s_tdata[LEVEL_W-1:0], s_tdata[LEVEL_W]);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CC_MAP_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            REG_CC_MAP:   cc_map_q   = value;
            REG_DEBOUNCE: debounce_q = value[DEB_W-1:0];
            REG_LONG:     long_q     = value[LONG_W-1:0];
            REG_MIN:      min_q      = value[MIN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_config(logic [CC_MAP_W-1:0] cc_map, logic [DEB_W-1:0] debounce,
                                logic [LONG_W-1:0] long_ticks, logic [MIN_W-1:0] min_ticks);
        write_reg(REG_CC_MAP, cc_map);
        write_reg(REG_DEBOUNCE, CC_MAP_W'(debounce));
        write_reg(REG_LONG, CC_MAP_W'(long_ticks));
        write_reg(REG_MIN, CC_MAP_W'(min_ticks));
    endtask

    task automatic push_tick(logic [LEVEL_W-1:0] levels, logic link, int count);
        repeat (count)
            tick_q.push_back({1'b0, link, levels});
    endtask

    // levels that persist for a few ticks, with the odd burst of noise
    task automatic push_walk(int count);
        logic link;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 5)
                walk_levels = LEVEL_W'($urandom);
            else
                for (int b = 0; b < LEVEL_W; b++)
                    if ($urandom_range(0, 99) < 18)
                        walk_levels[b] = ~walk_levels[b];
            link = ($urandom_range(0, 99) < 80);
            tick_q.push_back({1'b0, link, walk_levels});
        end
    endtask

    task automatic wait_drained();
        while (tick_q.size() != 0 || s_tvalid || expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_config(CC_MAP_W'({$urandom, $urandom}), 10'd0, 12'd6, 10'd1);
        write_reg(REG_UNUSED, '1);

        // all buttons released at once, then long presses on both channel buttons
        push_tick(6'h3F, 1'b1, 1);
        push_tick(6'h00, 1'b1, 4);
        push_tick(6'h3F, 1'b1, 2);
        push_tick(6'h3F, 1'b0, 1);
        push_tick(6'h2F, 1'b0, 6);
        push_tick(6'h3F, 1'b0, 2);
        push_tick(6'h1F, 1'b1, 6);
        push_tick(6'h3F, 1'b1, 2);
        push_tick(6'h00, 1'b0, 1);
        wait_drained();

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: write_config(CC_MAP_W'({$urandom, $urandom}), 10'd0, 12'd0, 10'd0);
                1: write_config('1, 10'd1, 12'd1, 10'd2);
                4: write_config('0, 10'd2, 12'd12, 10'd0);
                default: write_config(CC_MAP_W'({$urandom, $urandom}),
                                      DEB_W'($urandom_range(0, 3)),
                                      LONG_W'($urandom_range(2, 12)),
                                      MIN_W'($urandom_range(0, 4)));
            endcase
            send_idle = (p != 1);
            sink_idle = (p != 1);
            if (p == 3)
            begin
                push_walk(35);
                wait_drained();
                push_walk(34);
            end
            else
            begin
                push_walk(69);
                if (p == 2)
                    hold_request = 1'b1;
            end
            wait_drained();
        end

        if (failures == 0 && expected_events.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #(TIMEOUT);
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
src/bpmc_pkg.sv
src/bpmc_button.sv
src/button_press_to_midi_cc.sv
test/tb_button_press_to_midi_cc.sv
